// File: sv/lsqo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsqo_pkg
// Shared widths and constants for the stroked-line quad outline core.
// ----------------------------------------------------------------------------
package lsqo_pkg;

  localparam int COORD_BITS_DEFAULT = 16;
  localparam int PEN_BITS           = 8;
  localparam int OUT_BITS           = 18;

  // floor(w/3) for w < 256 as (w * 171) >> 9
  localparam int DIV3_MUL_BITS   = 8;
  localparam int DIV3_SHIFT      = 9;
  localparam logic [DIV3_MUL_BITS-1:0] DIV3_MUL = 8'd171;
  localparam int PAD_BITS        = 9;
  localparam logic [PAD_BITS-1:0] PAD_BIAS = 9'd2;

  typedef enum logic [1:0] {
    SHAPE_DIAG_SAME,
    SHAPE_DIAG_OPP,
    SHAPE_HORIZ,
    SHAPE_VERT
  } shape_t;

endpackage
`default_nettype wire

// File: sv/line_stroke_quad_outline_core.sv
`default_nettype none
// path: from input accept to result valid through the input register, then the result register
// throughput: one segment per cycle, set by the single combinational geometry pass
// between the two registers; ready drops only when both registers hold words and
// the result is stalled
// reset: synchronous, active high, clears both valid flags; payload is not reset
// ----------------------------------------------------------------------------
// line_stroke_quad_outline_core
// Computes the four corners of a quad enclosing a stroked line segment.
// ----------------------------------------------------------------------------
module line_stroke_quad_outline_core
  import lsqo_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire  signed [COORD_BITS-1:0] origin_x,
  input  wire  signed [COORD_BITS-1:0] origin_y,
  input  wire  signed [COORD_BITS-1:0] start_x,
  input  wire  signed [COORD_BITS-1:0] start_y,
  input  wire  signed [COORD_BITS-1:0] end_x,
  input  wire  signed [COORD_BITS-1:0] end_y,
  input  wire         [PEN_BITS-1:0]   stroke_width,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic signed [OUT_BITS-1:0]   corner0_x,
  output logic signed [OUT_BITS-1:0]   corner0_y,
  output logic signed [OUT_BITS-1:0]   corner1_x,
  output logic signed [OUT_BITS-1:0]   corner1_y,
  output logic signed [OUT_BITS-1:0]   corner2_x,
  output logic signed [OUT_BITS-1:0]   corner2_y,
  output logic signed [OUT_BITS-1:0]   corner3_x,
  output logic signed [OUT_BITS-1:0]   corner3_y
);

  localparam int WW  = (COORD_BITS + 3 > OUT_BITS) ? COORD_BITS + 3 : OUT_BITS;
  localparam int EXT = WW - COORD_BITS;
  localparam int PROD_BITS = PEN_BITS + DIV3_MUL_BITS;

  // input register
  logic                          s1_valid;
  logic signed [COORD_BITS-1:0]  s1_ox, s1_oy, s1_x1, s1_y1, s1_x2, s1_y2;
  logic        [PEN_BITS-1:0]    s1_w;
  logic                          s1_adv;

  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_ox <= origin_x;
      s1_oy <= origin_y;
      s1_x1 <= start_x;
      s1_y1 <= start_y;
      s1_x2 <= end_x;
      s1_y2 <= end_y;
      s1_w  <= stroke_width;
    end
  end

  // geometry
  logic signed [WW-1:0]        ox, oy, x1, y1, x2, y2;
  logic        [PROD_BITS-1:0] w_prod;
  logic        [PAD_BITS-1:0]  pad;
  logic signed [WW-1:0]        pad_w, px, py;
  logic signed [WW-1:0]        diff_x, diff_y, dx, dy, big, sml;
  logic                        x_lt, y_lt, near_diag;
  logic signed [WW-1:0]        sx, sy, ex, ey;
  shape_t                      shape;
  logic signed [WW-1:0]        c0x, c0y, c1x, c1y, c2x, c2y, c3x, c3y;

  always_comb begin
    ox = signed'({{EXT{s1_ox[COORD_BITS-1]}}, s1_ox});
    oy = signed'({{EXT{s1_oy[COORD_BITS-1]}}, s1_oy});
    x1 = signed'({{EXT{s1_x1[COORD_BITS-1]}}, s1_x1});
    y1 = signed'({{EXT{s1_y1[COORD_BITS-1]}}, s1_y1});
    x2 = signed'({{EXT{s1_x2[COORD_BITS-1]}}, s1_x2});
    y2 = signed'({{EXT{s1_y2[COORD_BITS-1]}}, s1_y2});

    // pad = w + floor(w/3) + 2 = floor(4w/3) + 2
    w_prod = PROD_BITS'(s1_w) * PROD_BITS'(DIV3_MUL);
    pad    = PAD_BITS'(s1_w) + PAD_BITS'(w_prod >> DIV3_SHIFT) + PAD_BIAS;
    pad_w  = signed'(WW'(pad));

    x_lt = x1 < x2;
    y_lt = y1 < y2;
    px   = x_lt ? -pad_w : pad_w;
    py   = y_lt ? -pad_w : pad_w;

    diff_x = x1 - x2;
    diff_y = y1 - y2;
    dx     = diff_x[WW-1] ? -diff_x : diff_x;
    dy     = diff_y[WW-1] ? -diff_y : diff_y;
    big    = (dx > dy) ? dx : dy;
    sml    = (dx > dy) ? dy : dx;

    // floor(2a/b) <= 2 written as 2a < 3b
    near_diag = (dx != '0) && (dy != '0) && ((big <<< 1) < (sml + (sml <<< 1)));

    if (near_diag) begin
      shape = (x_lt == y_lt) ? SHAPE_DIAG_SAME : SHAPE_DIAG_OPP;
    end else if (dx > dy) begin
      shape = SHAPE_HORIZ;
    end else begin
      shape = SHAPE_VERT;
    end

    sx = x1 + ox;
    sy = y1 + oy;
    ex = x2 + ox;
    ey = y2 + oy;

    unique case (shape)
      SHAPE_DIAG_SAME: begin
        c0x = sx;      c0y = sy + py;
        c1x = ex - px; c1y = ey;
        c2x = ex;      c2y = ey - py;
        c3x = sx + px; c3y = sy;
      end
      SHAPE_DIAG_OPP: begin
        c0x = sx + px; c0y = sy;
        c1x = ex;      c1y = ey - py;
        c2x = ex - px; c2y = ey;
        c3x = sx;      c3y = sy + py;
      end
      SHAPE_HORIZ: begin
        c0x = sx + px; c0y = sy + py;
        c1x = ex - px; c1y = ey + py;
        c2x = ex - px; c2y = ey - py;
        c3x = sx + px; c3y = sy - py;
      end
      default: begin
        c0x = sx + px; c0y = sy + py;
        c1x = ex + px; c1y = ey - py;
        c2x = ex - px; c2y = ey - py;
        c3x = sx - px; c3y = sy + py;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
    if (s1_adv && s1_valid) begin
      corner0_x <= c0x[OUT_BITS-1:0];
      corner0_y <= c0y[OUT_BITS-1:0];
      corner1_x <= c1x[OUT_BITS-1:0];
      corner1_y <= c1y[OUT_BITS-1:0];
      corner2_x <= c2x[OUT_BITS-1:0];
      corner2_y <= c2y[OUT_BITS-1:0];
      corner3_x <= c3x[OUT_BITS-1:0];
      corner3_y <= c3y[OUT_BITS-1:0];
    end
  end

`ifndef ASSERT_OFF
  a_ready_when_out_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while result register is empty");

  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while both registers are full");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> s1_valid)
    else $error("accepted word lost in input register");

  a_s1_moves_to_out: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_adv) |=> out_valid)
    else $error("word lost between input and result register");
`endif

endmodule
`default_nettype wire
